@@ hw/rtl/tccw_pkg.sv @@
// ============================================================================
// Text console char writer package
// Shared types, constants and the codepoint classifier.
// ============================================================================
package tccw_pkg;

    // Ring and lookahead sizes
    localparam int LINE_SLOTS = 16384;
    localparam int LOOKAHEAD  = 5;
    localparam int SLOT_W     = $clog2(LINE_SLOTS);
    localparam int LINES_W    = $clog2(LINE_SLOTS + 1);
    localparam int HCNT_W     = $clog2(LOOKAHEAD + 1);
    localparam int COL_W      = 9;

    // Front to back queue
    localparam int FIFO_DEPTH = 2;
    localparam int QPTR_W     = $clog2(FIFO_DEPTH);
    localparam int QFILL_W    = $clog2(FIFO_DEPTH + 1);

    // Config register indexes
    localparam logic [1:0] REG_LINE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_MAX_LINES   = 2'd1;
    localparam logic [1:0] REG_LEFT_MARGIN = 2'd2;

    localparam logic [7:0]  RST_LINE_WIDTH  = 8'd80;
    localparam logic [14:0] RST_MAX_LINES   = 15'd1024;
    localparam logic [7:0]  RST_LEFT_MARGIN = 8'd0;

    localparam int TAB_STEP = 8;

    // Character codes
    localparam logic [20:0] CP_TAB = 21'd9;
    localparam logic [20:0] CP_NL  = 21'd10;
    localparam logic [20:0] CP_CR  = 21'd13;
    localparam logic [20:0] CP_AMP = 21'h26;
    localparam logic [20:0] CP_C   = 21'h63;
    localparam logic [20:0] CP_R   = 21'h72;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_LINE  = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DRAIN,
        ST_PUT,
        ST_WRITE,
        ST_FINISH
    } back_state_t;

    typedef struct packed {
        logic [20:0] cp;
        logic        is_amp;
        logic        is_c;
        logic        is_r;
        logic        is_nl;
        logic        is_cr;
        logic        is_tab;
        logic        hex_ok;
        logic [3:0]  hex;
    } cls_t;

    typedef struct packed {
        logic        action;
        cls_t        ch;
        logic [31:0] base;
        logic        last;
    } item_t;

    typedef struct packed {
        logic [7:0]  line_width;
        logic [14:0] max_lines;
        logic [7:0]  left_margin;
    } cfg_t;

    typedef struct packed {
        kind_t               kind;
        logic [SLOT_W-1:0]   slot;
        logic [7:0]          column;
        logic [20:0]         glyph;
        logic [31:0]         color;
        logic [LINES_W-1:0]  lines;
    } res_t;

    // Tag a codepoint with everything the back sequencer asks about it
    function automatic cls_t classify(input logic [20:0] cp);
        cls_t       r;
        logic [7:0] c;
        c        = cp[7:0];
        r.cp     = cp;
        r.is_amp = (cp == CP_AMP);
        r.is_c   = (cp == CP_C);
        r.is_r   = (cp == CP_R);
        r.is_nl  = (cp == CP_NL);
        r.is_cr  = (cp == CP_CR);
        r.is_tab = (cp == CP_TAB);
        r.hex_ok = 1'b1;
        r.hex    = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.hex = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r.hex = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r.hex = 4'(c - 8'h37);
        end else begin
            r.hex_ok = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/tccw_front.sv @@
// ============================================================================
// Text console char writer front
// Accepts input items, classifies the codepoint and queues them for the back.
// ============================================================================
module tccw_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [55:0]          s_tdata,
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    output logic                 q_valid,
    output tccw_pkg::item_t      q_item,
    input  logic                 q_pop
);

    tccw_pkg::item_t                  mem_reg [tccw_pkg::FIFO_DEPTH];
    logic [tccw_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [tccw_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [tccw_pkg::QFILL_W-1:0]     fill_reg, fill_next;
    tccw_pkg::item_t                  in_item;
    logic                             push;
    logic                             pop;

    assign s_tready = (fill_reg != tccw_pkg::QFILL_W'(tccw_pkg::FIFO_DEPTH));
    assign q_valid  = (fill_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb begin
        in_item.action = s_tuser;
        in_item.ch     = tccw_pkg::classify(s_tdata[20:0]);
        in_item.base   = s_tdata[52:21];
        in_item.last   = s_tlast;
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == tccw_pkg::QPTR_W'(tccw_pkg::FIFO_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == tccw_pkg::QPTR_W'(tccw_pkg::FIFO_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ hw/rtl/tccw_back.sv @@
// ============================================================================
// Text console char writer back
// Sequencer that drains the lookahead buffer and emits ring writes.
// ============================================================================
module tccw_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tccw_pkg::cfg_t       cfg,
    input  logic                 q_valid,
    input  tccw_pkg::item_t      q_item,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tccw_pkg::res_t       m_res,
    output logic                 m_last
);

    tccw_pkg::back_state_t              st_reg, st_next;
    logic [tccw_pkg::SLOT_W-1:0]        head_reg, head_next;
    logic [tccw_pkg::LINES_W-1:0]       lines_reg, lines_next;
    logic [tccw_pkg::COL_W-1:0]         cur_reg, cur_next;
    logic [31:0]                        color_reg, color_next;
    tccw_pkg::cls_t                     held_reg [tccw_pkg::LOOKAHEAD];
    tccw_pkg::cls_t                     held_next [tccw_pkg::LOOKAHEAD];
    logic [tccw_pkg::HCNT_W-1:0]        cnt_reg, cnt_next;
    logic                               open_reg, open_next;
    tccw_pkg::item_t                    item_reg, item_next;
    tccw_pkg::res_t                     pend_reg, pend_next;
    logic                               pend_vld_reg, pend_vld_next;
    tccw_pkg::res_t                     out_reg;
    logic                               out_last_reg;
    logic                               out_vld_reg;

    logic                               out_free;
    logic                               can_emit;
    logic                               emit;
    tccw_pkg::res_t                     emit_res;
    logic                               push_out;
    logic                               push_last;

    logic [tccw_pkg::LINES_W-1:0]       cap;
    logic [tccw_pkg::SLOT_W-1:0]        sl_head;
    logic [tccw_pkg::LINES_W-1:0]       sl_lines;
    logic [tccw_pkg::COL_W-1:0]         width9;
    logic [tccw_pkg::COL_W-1:0]         margin9;
    logic [tccw_pkg::COL_W-1:0]         tab_col;
    tccw_pkg::res_t                     line_res;
    tccw_pkg::res_t                     write_res;
    tccw_pkg::res_t                     first_res;
    tccw_pkg::res_t                     clear_res;

    assign out_free = !out_vld_reg || m_ready;
    assign can_emit = !pend_vld_reg || out_free;
    assign m_valid  = out_vld_reg;
    assign m_res    = out_reg;
    assign m_last   = out_last_reg;

    assign width9  = {1'b0, cfg.line_width};
    assign margin9 = {1'b0, cfg.left_margin};
    assign tab_col = (cur_reg + tccw_pkg::COL_W'(tccw_pkg::TAB_STEP))
                     & ~tccw_pkg::COL_W'(tccw_pkg::TAB_STEP - 1);

    // Start-line values: advance head, bump count up to the clamped limit
    always_comb begin
        if (cfg.max_lines == '0) begin
            cap = tccw_pkg::LINES_W'(1);
        end else if (tccw_pkg::LINES_W'(cfg.max_lines) >
                     tccw_pkg::LINES_W'(tccw_pkg::LINE_SLOTS)) begin
            cap = tccw_pkg::LINES_W'(tccw_pkg::LINE_SLOTS);
        end else begin
            cap = tccw_pkg::LINES_W'(cfg.max_lines);
        end
        sl_head  = (head_reg == tccw_pkg::SLOT_W'(tccw_pkg::LINE_SLOTS - 1))
                   ? '0 : head_reg + 1'b1;
        sl_lines = (lines_reg >= cap) ? cap : lines_reg + 1'b1;
    end

    always_comb begin
        line_res        = '0;
        line_res.kind   = tccw_pkg::KIND_LINE;
        line_res.slot   = sl_head;
        line_res.lines  = sl_lines;

        first_res       = '0;
        first_res.kind  = tccw_pkg::KIND_LINE;
        first_res.slot  = head_reg;
        first_res.lines = tccw_pkg::LINES_W'(1);

        clear_res       = '0;
        clear_res.kind  = tccw_pkg::KIND_CLEAR;
        clear_res.slot  = head_reg;

        write_res.kind   = tccw_pkg::KIND_CHAR;
        write_res.slot   = head_reg;
        write_res.column = cur_reg[7:0];
        write_res.glyph  = held_reg[0].cp;
        write_res.color  = color_reg;
        write_res.lines  = lines_reg;
    end

    always_comb begin
        st_next       = st_reg;
        head_next     = head_reg;
        lines_next    = lines_reg;
        cur_next      = cur_reg;
        color_next    = color_reg;
        held_next     = held_reg;
        cnt_next      = cnt_reg;
        open_next     = open_reg;
        item_next     = item_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        emit          = 1'b0;
        emit_res      = write_res;
        push_out      = 1'b0;
        push_last     = 1'b0;
        q_pop         = 1'b0;

        case (st_reg)
            tccw_pkg::ST_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    st_next   = tccw_pkg::ST_EXEC;
                end
            end

            tccw_pkg::ST_EXEC: begin
                if (item_reg.action) begin
                    emit     = 1'b1;
                    emit_res = clear_res;
                    if (can_emit) begin
                        lines_next = '0;
                        cur_next   = margin9;
                        cnt_next   = '0;
                        open_next  = 1'b0;
                        st_next    = tccw_pkg::ST_FINISH;
                    end
                end else begin
                    if (!open_reg && lines_reg == '0) begin
                        emit     = 1'b1;
                        emit_res = first_res;
                    end
                    if (!emit || can_emit) begin
                        if (!open_reg) begin
                            if (lines_reg == '0) begin
                                lines_next = tccw_pkg::LINES_W'(1);
                            end
                            color_next = item_reg.base;
                            open_next  = 1'b1;
                        end
                        for (int i = 0; i < tccw_pkg::LOOKAHEAD; i++) begin
                            if (tccw_pkg::HCNT_W'(i) == cnt_reg) begin
                                held_next[i] = item_reg.ch;
                            end
                        end
                        cnt_next = cnt_reg + 1'b1;
                        st_next  = tccw_pkg::ST_DRAIN;
                    end
                end
            end

            tccw_pkg::ST_DRAIN: begin
                if (cnt_reg == '0) begin
                    st_next = tccw_pkg::ST_FINISH;
                end else if (!held_reg[0].is_amp) begin
                    st_next = tccw_pkg::ST_PUT;
                end else if (cnt_reg == tccw_pkg::HCNT_W'(tccw_pkg::LOOKAHEAD)) begin
                    if (held_reg[1].is_c && held_reg[2].hex_ok && held_reg[3].hex_ok
                        && held_reg[4].hex_ok) begin
                        // digit times 17 is the digit repeated in both nibbles
                        color_next = {held_reg[2].hex, held_reg[2].hex,
                                      held_reg[3].hex, held_reg[3].hex,
                                      held_reg[4].hex, held_reg[4].hex, 8'hFF};
                        cnt_next   = '0;
                    end else if (held_reg[1].is_r) begin
                        color_next = item_reg.base;
                        for (int i = 0; i < tccw_pkg::LOOKAHEAD - 2; i++) begin
                            held_next[i] = held_reg[i + 2];
                        end
                        cnt_next = cnt_reg - tccw_pkg::HCNT_W'(2);
                    end else begin
                        st_next = tccw_pkg::ST_PUT;
                    end
                end else if (item_reg.last) begin
                    st_next = tccw_pkg::ST_PUT;
                end else begin
                    st_next = tccw_pkg::ST_FINISH;
                end
            end

            tccw_pkg::ST_PUT: begin
                if (held_reg[0].is_nl || (held_reg[0].is_tab && tab_col >= width9)) begin
                    emit     = 1'b1;
                    emit_res = line_res;
                    if (can_emit) begin
                        head_next  = sl_head;
                        lines_next = sl_lines;
                        cur_next   = margin9;
                        for (int i = 0; i < tccw_pkg::LOOKAHEAD - 1; i++) begin
                            held_next[i] = held_reg[i + 1];
                        end
                        cnt_next = cnt_reg - 1'b1;
                        st_next  = tccw_pkg::ST_DRAIN;
                    end
                end else if (held_reg[0].is_cr || held_reg[0].is_tab) begin
                    cur_next = held_reg[0].is_cr ? margin9 : tab_col;
                    for (int i = 0; i < tccw_pkg::LOOKAHEAD - 1; i++) begin
                        held_next[i] = held_reg[i + 1];
                    end
                    cnt_next = cnt_reg - 1'b1;
                    st_next  = tccw_pkg::ST_DRAIN;
                end else if (cur_reg >= width9) begin
                    // wrap first, then the write step checks the new column
                    emit     = 1'b1;
                    emit_res = line_res;
                    if (can_emit) begin
                        head_next  = sl_head;
                        lines_next = sl_lines;
                        cur_next   = margin9;
                        st_next    = tccw_pkg::ST_WRITE;
                    end
                end else begin
                    st_next = tccw_pkg::ST_WRITE;
                end
            end

            tccw_pkg::ST_WRITE: begin
                if (cur_reg < width9) begin
                    emit     = 1'b1;
                    emit_res = write_res;
                end
                if (!emit || can_emit) begin
                    cur_next = cur_reg + 1'b1;
                    for (int i = 0; i < tccw_pkg::LOOKAHEAD - 1; i++) begin
                        held_next[i] = held_reg[i + 1];
                    end
                    cnt_next = cnt_reg - 1'b1;
                    st_next  = tccw_pkg::ST_DRAIN;
                end
            end

            tccw_pkg::ST_FINISH: begin
                if (!pend_vld_reg || out_free) begin
                    if (pend_vld_reg) begin
                        push_out      = 1'b1;
                        push_last     = 1'b1;
                        pend_vld_next = 1'b0;
                    end
                    if (item_reg.last) begin
                        cnt_next  = '0;
                        open_next = 1'b0;
                    end
                    st_next = tccw_pkg::ST_IDLE;
                end
            end

            default: begin
                st_next = tccw_pkg::ST_IDLE;
            end
        endcase

        // Hold one result back so the final one can carry the last flag
        if (emit && can_emit) begin
            if (pend_vld_reg) begin
                push_out = 1'b1;
            end
            pend_next     = emit_res;
            pend_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= tccw_pkg::ST_IDLE;
            head_reg     <= '0;
            lines_reg    <= '0;
            cur_reg      <= '0;
            color_reg    <= '0;
            cnt_reg      <= '0;
            open_reg     <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            st_reg       <= st_next;
            head_reg     <= head_next;
            lines_reg    <= lines_next;
            cur_reg      <= cur_next;
            color_reg    <= color_next;
            cnt_reg      <= cnt_next;
            open_reg     <= open_next;
            pend_vld_reg <= pend_vld_next;
            if (push_out) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        pend_reg <= pend_next;
        held_reg <= held_next;
        if (push_out) begin
            out_reg      <= pend_reg;
            out_last_reg <= push_last;
        end
    end

endmodule

@@ hw/rtl/text_console_char_writer.sv @@
// ============================================================================
// Text console char writer
// Turns a codepoint stream into character writes for a ring of text lines.
// ============================================================================
// Usage:
//   s_* carries one codepoint per item with the text's base color; s_tlast
//   marks the last codepoint of a text, s_tuser high asks for a clear of the
//   ring. m_* carries the resulting ring writes, zero or more per item; m_tlast
//   marks the last result of an input item. cfg_* writes line_width,
//   max_lines and left_margin; write them only while the block is idle.
// Sequencing and throughput:
//   A two-entry queue decouples the front from the back sequencer, which
//   runs one item at a time, one step per cycle while its results are
//   taken: a plain character goes through pop, open, drain, put, write,
//   drain and finish, also when it wraps; a newline, return or tab skips
//   the write step, and an item that is only held ends after its first drain.
//   A color code is consumed in one drain step. A result waits until the next
//   one or the end of its item is known.
// Reset:
//   aresetn (synchronous, active low) empties the queue and the ring state,
//   drops held codepoints and restores the config registers to 80, 1024, 0.
// Back pressure:
//   When m_tready is low the output register holds its item; the back stalls
//   only on its next result, and the queue keeps accepting until full.
// ============================================================================
module text_console_char_writer (
    input  logic        aclk,
    input  logic        aresetn,
    // input item channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // codepoint[20:0], base_color[52:21], zero pad
    input  logic        s_tuser,   // action
    input  logic        s_tlast,   // last_of_text
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // slot[13:0], column[21:14], glyph[42:22],
                                   // color[74:43], lines_held[89:75], zero pad
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast,   // last
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [14:0] cfg_wdata
);

    tccw_pkg::cfg_t     cfg_reg;
    logic               q_valid;
    tccw_pkg::item_t    q_item;
    logic               q_pop;
    tccw_pkg::res_t     res;
    logic               res_last;

    // Config registers: take a write whenever the enable is high
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.line_width  <= tccw_pkg::RST_LINE_WIDTH;
            cfg_reg.max_lines   <= tccw_pkg::RST_MAX_LINES;
            cfg_reg.left_margin <= tccw_pkg::RST_LEFT_MARGIN;
        end else if (cfg_we) begin
            case (cfg_addr)
                tccw_pkg::REG_LINE_WIDTH:  cfg_reg.line_width  <= cfg_wdata[7:0];
                tccw_pkg::REG_MAX_LINES:   cfg_reg.max_lines   <= cfg_wdata;
                tccw_pkg::REG_LEFT_MARGIN: cfg_reg.left_margin <= cfg_wdata[7:0];
                default: begin
                    // no register at this index: drop the write
                end
            endcase
        end
    end

    // Front: accept, classify, queue
    tccw_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // Back: drain the lookahead and produce ring writes
    tccw_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_res    (res),
        .m_last   (res_last)
    );

    // Pack result fields, lowest field first
    assign m_tdata = {6'd0, res.lines, res.color, res.glyph, res.column, res.slot};
    assign m_tuser = res.kind;
    assign m_tlast = res_last;

endmodule

@@ hw/rtl/tccw_checker.sv @@
// ============================================================================
// Text console char writer checker
// Port-level assertions on the result channel, bound to the top level.
// ============================================================================
module tccw_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast
);

    // Hold a stalled result unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                   && $stable(m_tlast))
        else $error("stalled result changed");

    // Output register is empty right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A clear is the only result of its item and leaves the ring empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == tccw_pkg::KIND_CLEAR |-> m_tlast && m_tdata[89:75] == '0)
        else $error("clear result malformed");

    // A new-line result carries no column, glyph or color and a nonzero count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == tccw_pkg::KIND_LINE
            |-> m_tdata[74:14] == '0 && m_tdata[89:75] != '0)
        else $error("line result malformed");

    // A character is only written into a ring that holds a line
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == tccw_pkg::KIND_CHAR |-> m_tdata[89:75] != '0)
        else $error("character written to empty ring");

endmodule

bind text_console_char_writer tccw_checker u_tccw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
